// ===== rtl/qmp_pkg.sv =====
// shared widths, register indexes and constants of the magnitude pruning block
package qmp_pkg;

  localparam int unsigned W_W        = 8;
  localparam int unsigned SCALE_W    = 32;
  localparam int unsigned PROD_W     = 40;
  localparam int unsigned MAG_W      = 39;
  localparam int unsigned ROWLEN_W   = 7;
  localparam int unsigned RATIO_W    = 17;
  localparam int unsigned RATIO_FRAC = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_FRACTION = 2'd1;

  localparam logic [ROWLEN_W-1:0] ROW_LENGTH_RST = 7'd64;
  localparam logic [RATIO_W-1:0]  RATIO_ONE      = 17'h10000;

endpackage

// ===== rtl/qmp_if.sv =====
// valid/ready channel interfaces for weights in, pruned weights out and register writes

interface qmp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [qmp_pkg::W_W-1:0]     weight;
  logic signed [qmp_pkg::SCALE_W-1:0] group_scale;
  logic                               final_row;

  modport source (output valid, weight, group_scale, final_row, input ready);
  modport sink   (input valid, weight, group_scale, final_row, output ready);
endinterface

interface qmp_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [qmp_pkg::W_W-1:0] pruned_weight;
  logic                           row_last;
  logic                           matrix_last;

  modport source (output valid, pruned_weight, row_last, matrix_last, input ready);
  modport sink   (input valid, pruned_weight, row_last, matrix_last, output ready);
endinterface

interface qmp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qmp_pkg::CFG_IDX_W-1:0]     index;
  logic [qmp_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/qmp_ram.sv =====
// generic single write port, single read port ram with registered read data
module qmp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/qmp_mag.sv =====
// magnitude unit: registered signed weight times scale, then absolute value for the store
module qmp_mag #(
  parameter int unsigned AW = 6
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [AW-1:0]                      addr_i,
  input  logic signed [qmp_pkg::W_W-1:0]     weight_i,
  input  logic signed [qmp_pkg::SCALE_W-1:0] scale_i,
  output logic                               we_o,
  output logic [AW-1:0]                      waddr_o,
  output logic [qmp_pkg::W_W-1:0]            wweight_o,
  output logic [qmp_pkg::MAG_W-1:0]          wmag_o
);

  logic                              vld_q;
  logic [AW-1:0]                     addr_q;
  logic [qmp_pkg::W_W-1:0]           weight_q;
  logic signed [qmp_pkg::PROD_W-1:0] prod_d;
  logic [qmp_pkg::PROD_W-1:0]        prod_q;
  logic [qmp_pkg::PROD_W-1:0]        neg;

  assign prod_d = qmp_pkg::PROD_W'(weight_i) * qmp_pkg::PROD_W'(scale_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      addr_q   <= addr_i;
      weight_q <= weight_i;
      prod_q   <= prod_d;
    end
  end

  // |p| never exceeds 2^38, so the negated product fits the store width
  assign neg       = ~prod_q + qmp_pkg::PROD_W'(1);
  assign we_o      = vld_q;
  assign waddr_o   = addr_q;
  assign wweight_o = weight_q;
  assign wmag_o    = prod_q[qmp_pkg::PROD_W-1] ? neg[qmp_pkg::MAG_W-1:0]
                                               : prod_q[qmp_pkg::MAG_W-1:0];

endmodule

// ===== rtl/quantized_magnitude_prune_row.sv =====
// top level: row store, threshold selection and output register of the pruning block
//
// Weights arrive one per transfer on in_i together with their group scale (Q8.24)
// and a final_row mark. Each is stored with |weight * scale| in two memories.
// Items that do not complete a row are taken back to back, one per cycle.
// The item that reaches row_length closes the row: in_i.ready drops and the row
// is emitted on out_o in arrival order, weights at or below the k-th smallest
// magnitude replaced by zero, k = floor(n * cut_fraction / 65536).
// n is the row length. The magnitude memory has one read port, so the count of
// smaller magnitudes for one weight walks the whole row one entry a cycle
// (skipped when k is 0).
// Results sit in an output register; a stalled receiver freezes the walk
// only at the point where the next result would be loaded, and new input
// is taken again as soon as the last result of the row is in that register.
// Register writes on cfg_i are always taken; they are meant to happen only while
// the block is idle. Reset clears the fill count and final mark and loads
// row_length 64 and cut_fraction 0; the stores need no clearing pass.
module quantized_magnitude_prune_row #(
  parameter int unsigned ROW_MAX = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qmp_in_if.sink    in_i,
  qmp_out_if.source out_o,
  qmp_cfg_if.sink   cfg_i
);

  localparam int unsigned AW   = $clog2(ROW_MAX);
  localparam int unsigned CW   = $clog2(ROW_MAX + 1);
  localparam int unsigned KP_W = CW + qmp_pkg::RATIO_W;

  localparam logic [2:0] ST_IN   = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_LD   = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [qmp_pkg::ROWLEN_W-1:0] row_len_q;
  logic [qmp_pkg::RATIO_W-1:0]  ratio_q;
  logic [qmp_pkg::RATIO_W-1:0]  ratio_sat;
  logic [CW-1:0]                eff_len;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] fill_q, fill_inc;
  logic [CW-1:0] n_q, k_q, k_d;
  logic [KP_W-1:0] kprod;
  logic          final_q;
  logic          in_acc, row_close;

  logic [AW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [qmp_pkg::MAG_W-1:0] mag_i_q;
  logic          is_last;

  logic          rd_en, w_re;
  logic [AW-1:0] rd_addr;
  logic          out_free, out_load, emit_done;

  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [qmp_pkg::W_W-1:0]     wr_weight;
  logic [qmp_pkg::MAG_W-1:0]   wr_mag;
  logic [qmp_pkg::W_W-1:0]     w_rdata;
  logic [qmp_pkg::MAG_W-1:0]   mag_rdata;

  logic                        out_valid_q;
  logic [qmp_pkg::W_W-1:0]     out_weight_q;
  logic                        out_row_last_q;
  logic                        out_matrix_last_q;

  // register port
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= qmp_pkg::ROW_LENGTH_RST;
      ratio_q   <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        qmp_pkg::REG_ROW_LENGTH:   row_len_q <= cfg_i.data[qmp_pkg::ROWLEN_W-1:0];
        qmp_pkg::REG_CUT_FRACTION: ratio_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_len_q == '0) begin
      eff_len = CW'(1);
    end else if (row_len_q > qmp_pkg::ROWLEN_W'(ROW_MAX)) begin
      eff_len = CW'(ROW_MAX);
    end else begin
      eff_len = row_len_q[CW-1:0];
    end
  end

  assign ratio_sat = (ratio_q > qmp_pkg::RATIO_ONE) ? qmp_pkg::RATIO_ONE : ratio_q;

  // ingest
  assign in_i.ready = (state_q == ST_IN);
  assign in_acc     = in_i.valid && in_i.ready;
  assign fill_inc   = fill_q + CW'(1);
  assign row_close  = in_acc && (fill_inc >= eff_len);
  assign kprod      = KP_W'(fill_inc) * KP_W'(ratio_sat);
  assign k_d        = kprod[qmp_pkg::RATIO_FRAC +: CW];

  qmp_mag #(
    .AW (AW)
  ) u_mag (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_acc),
    .addr_i    (fill_q[AW-1:0]),
    .weight_i  (in_i.weight),
    .scale_i   (in_i.group_scale),
    .we_o      (wr_en),
    .waddr_o   (wr_addr),
    .wweight_o (wr_weight),
    .wmag_o    (wr_mag)
  );

  qmp_ram #(
    .WIDTH (qmp_pkg::W_W),
    .DEPTH (ROW_MAX)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_weight),
    .re_i    (w_re),
    .raddr_i (i_q),
    .rdata_o (w_rdata)
  );

  qmp_ram #(
    .WIDTH (qmp_pkg::MAG_W),
    .DEPTH (ROW_MAX)
  ) u_mag_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_mag),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (mag_rdata)
  );

  // selection sequencer
  assign out_free = !out_valid_q || out_o.ready;
  assign is_last  = (CW'(i_q) + CW'(1)) == n_q;
  assign w_re     = (state_q == ST_RD);

  always_comb begin
    state_d   = state_q;
    rd_en     = 1'b0;
    rd_addr   = i_q;
    i_d       = i_q;
    j_d       = j_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    emit_done = 1'b0;
    case (state_q)
      ST_IN: begin
        if (row_close) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // last write of the row lands in this cycle
        i_d     = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_LD;
      end
      ST_LD: begin
        cnt_d = '0;
        if (k_q == '0) begin
          state_d = ST_OUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = '0;
          j_d     = CW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (mag_rdata < mag_i_q) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (j_q < n_q) begin
          rd_en   = 1'b1;
          rd_addr = j_q[AW-1:0];
          j_d     = j_q + CW'(1);
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (is_last) begin
            emit_done = 1'b1;
            state_d   = ST_IN;
          end else begin
            i_d     = i_q + AW'(1);
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IN;
      fill_q  <= '0;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        fill_q  <= row_close ? '0 : fill_inc;
        final_q <= final_q | in_i.final_row;
      end else if (emit_done) begin
        final_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_close) begin
      n_q <= fill_inc;
      k_q <= k_d;
    end
    if (state_q == ST_LD) begin
      mag_i_q <= mag_rdata;
    end
    i_q   <= i_d;
    j_q   <= j_d;
    cnt_q <= cnt_d;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_weight_q      <= (cnt_q < k_q) ? '0 : w_rdata;
      out_row_last_q    <= is_last;
      out_matrix_last_q <= is_last && final_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pruned_weight = out_weight_q;
  assign out_o.row_last      = out_row_last_q;
  assign out_o.matrix_last   = out_matrix_last_q;

endmodule

// ===== rtl/qmp_chk.sv =====
// port-level checker for the pruning block and its bind to the top level
module qmp_chk (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [qmp_pkg::W_W-1:0] out_weight_i,
  input logic                    out_row_last_i,
  input logic                    out_matrix_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_weight_i) && $stable(out_row_last_i) && $stable(out_matrix_last_i))
    else $error("stalled result changed");

  // while a row is still being emitted, no new weight may enter
  a_no_ingest_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_row_last_i |-> !in_ready_i)
    else $error("input taken in the middle of row emission");

  a_matrix_last_on_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_matrix_last_i |-> out_row_last_i)
    else $error("matrix end flagged away from a row end");

endmodule

bind quantized_magnitude_prune_row qmp_chk u_qmp_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_weight_i      (out_o.pruned_weight),
  .out_row_last_i    (out_o.row_last),
  .out_matrix_last_i (out_o.matrix_last)
);

// ===== tb/sv/tb_quantized_magnitude_prune_row.sv =====
// testbench of the row magnitude pruning block: predicted rows checked against emitted weights
module tb_quantized_magnitude_prune_row;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_MAX       = 64;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = ROW_MAX + 8;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  typedef struct packed {
    logic signed [qmp_pkg::W_W-1:0] weight;
    logic                           row_last;
    logic                           matrix_last;
  } pruned_t;

  logic clk;
  logic rst_n;

  qmp_in_if  in_bus ();
  qmp_out_if out_bus ();
  qmp_cfg_if cfg_bus ();

  quantized_magnitude_prune_row #(
    .ROW_MAX(ROW_MAX)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  // predictor state
  logic signed [qmp_pkg::W_W-1:0]   row_weight [ROW_MAX];
  logic        [qmp_pkg::MAG_W-1:0] row_mag    [ROW_MAX];
  int unsigned                      fill;
  bit                               final_seen;
  logic [qmp_pkg::ROWLEN_W-1:0]     cur_length;
  logic [qmp_pkg::RATIO_W-1:0]      cur_ratio;
  pruned_t                          pending_q [$];

  int unsigned errors;
  int unsigned weights_taken;
  int unsigned results_checked;
  int unsigned rows_checked;
  int unsigned reg_writes;
  int unsigned cycle_count;

  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  bit          hold_go;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [qmp_pkg::MAG_W-1:0] magnitude(
      input logic signed [qmp_pkg::W_W-1:0] w,
      input logic signed [qmp_pkg::SCALE_W-1:0] s);
    longint p;
    p = longint'(w) * longint'(s);
    if (p < 0) p = -p;
    return p[qmp_pkg::MAG_W-1:0];
  endfunction

  function automatic int unsigned effective_length(input logic [qmp_pkg::ROWLEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > ROW_MAX) return ROW_MAX;
    return 32'(len);
  endfunction

  // threshold selection: a weight is dropped when fewer than k magnitudes lie below it
  function void emit_row();
    int unsigned n;
    int unsigned k;
    int unsigned below;
    logic [qmp_pkg::RATIO_W-1:0] ratio;
    pruned_t r;
    n = fill;
    ratio = (cur_ratio > qmp_pkg::RATIO_ONE) ? qmp_pkg::RATIO_ONE : cur_ratio;
    k = (n * ratio) >> qmp_pkg::RATIO_FRAC;
    for (int i = 0; i < n; i++) begin
      below = 0;
      if (k != 0)
        for (int j = 0; j < n; j++)
          if (row_mag[j] < row_mag[i]) below++;
      r.weight      = (k != 0 && below < k) ? '0 : row_weight[i];
      r.row_last    = (i == n - 1);
      r.matrix_last = (i == n - 1) && final_seen;
      pending_q.push_back(r);
    end
    fill = 0;
    final_seen = 1'b0;
  endfunction

  function void take_weight(input logic signed [qmp_pkg::W_W-1:0] w,
                            input logic signed [qmp_pkg::SCALE_W-1:0] s, input logic fin);
    if (fill < ROW_MAX) begin
      row_weight[fill] = w;
      row_mag[fill] = magnitude(w, s);
      fill++;
    end
    if (fin) final_seen = 1'b1;
    if (fill >= effective_length(cur_length)) emit_row();
  endfunction

  always @(posedge clk or negedge rst_n) begin : row_tracker
    pruned_t due;
    if (!rst_n) begin
      fill = 0;
      final_seen = 1'b0;
      cur_length = qmp_pkg::ROW_LENGTH_RST;
      cur_ratio = '0;
      pending_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing pending: pruned_weight %0d row_last %0b",
                 out_bus.pruned_weight, out_bus.row_last);
          errors++;
        end else begin
          due = pending_q.pop_front();
          if (out_bus.pruned_weight !== due.weight) begin
            $error("pruned_weight: expected %0d, got %0d", due.weight, out_bus.pruned_weight);
            errors++;
          end
          if (out_bus.row_last !== due.row_last) begin
            $error("row_last: expected %0b, got %0b", due.row_last, out_bus.row_last);
            errors++;
          end
          if (out_bus.matrix_last !== due.matrix_last) begin
            $error("matrix_last: expected %0b, got %0b", due.matrix_last, out_bus.matrix_last);
            errors++;
          end
          results_checked++;
          if (due.row_last) rows_checked++;
        end
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          qmp_pkg::REG_ROW_LENGTH:   cur_length = cfg_bus.data[qmp_pkg::ROWLEN_W-1:0];
          qmp_pkg::REG_CUT_FRACTION: cur_ratio = cfg_bus.data[qmp_pkg::RATIO_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        take_weight(in_bus.weight, in_bus.group_scale, in_bus.final_row);
        weights_taken++;
      end
    end
  end

  // long hold-off of the receiver, counted here
  always @(posedge clk) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
    else if (hold_go) hold_left <= HOLD_CYCLES;
  end

  always @(posedge clk)
    out_bus.ready <= (hold_left == 0) && !hold_go && ($urandom_range(99) >= sink_stall_pct);

  task automatic send_weight(input logic signed [qmp_pkg::W_W-1:0] w,
                             input logic signed [qmp_pkg::SCALE_W-1:0] s, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.weight      <= w;
    in_bus.group_scale <= s;
    in_bus.final_row   <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // step past the current edge so the tracker has seen the last transfer
  task automatic wait_quiet(input int unsigned extra);
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [qmp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qmp_pkg::CFG_DATA_W-1:0] value);
    wait_quiet(SETTLE_CYCLES);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    reg_writes++;
  endtask

  function automatic logic [qmp_pkg::SCALE_W-1:0] pick_scale();
    case ($urandom_range(5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(15);
      3:       return 32'd0 - $urandom_range(1, 15);
      default: return $urandom();
    endcase
  endfunction

  // groups of four share a scale; some rows use tiny weights to force ties
  task automatic send_random_row(input int unsigned n);
    logic [qmp_pkg::SCALE_W-1:0] scale;
    logic [qmp_pkg::W_W-1:0]     w;
    bit                          tie_heavy;
    tie_heavy = ($urandom_range(2) == 0);
    for (int i = 0; i < n; i++) begin
      if (i % 4 == 0) scale = pick_scale();
      w = tie_heavy ? qmp_pkg::W_W'($urandom_range(6)) - 8'd3 : qmp_pkg::W_W'($urandom());
      send_weight(w, scale, $urandom_range(11) == 0);
    end
  endtask

  task automatic test_field_extremes();
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd4);
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'd0);
    send_weight(-8'sd128, 32'h8000_0000, 1'b0);
    send_weight(8'sd127, 32'h7FFF_FFFF, 1'b0);
    send_weight(8'sd0, 32'h0000_0000, 1'b1);
    send_weight(-8'sd1, 32'h0000_0001, 1'b0);
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'hC000);
    send_weight(-8'sd128, 32'h8000_0000, 1'b0);
    send_weight(8'sd127, 32'h7FFF_FFFF, 1'b0);
    send_weight(8'sd0, 32'h0000_0000, 1'b0);
    send_weight(-8'sd1, 32'h0000_0001, 1'b1);
  endtask

  task automatic test_threshold_ties();
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd4);
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'h8000);
    send_weight(8'sd3, 32'h0000_0001, 1'b0);
    send_weight(-8'sd3, 32'h0000_0001, 1'b0);
    send_weight(8'sd3, 32'hFFFF_FFFF, 1'b0);
    send_weight(8'sd1, 32'h0000_0001, 1'b0);
  endtask

  task automatic test_ratio_saturation();
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd2);
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'h1FFFF);
    send_weight(8'sd100, 32'h0100_0000, 1'b0);
    send_weight(-8'sd5, 32'h0000_0002, 1'b1);
  endtask

  task automatic test_zero_row_length();
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd0);
    write_reg(qmp_pkg::REG_CUT_FRACTION, qmp_pkg::RATIO_ONE);
    send_weight(8'sd77, 32'h0000_1234, 1'b0);
  endtask

  task automatic test_length_lowered_midrow();
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd8);
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'h8000);
    send_weight(8'sd10, 32'h0000_0010, 1'b0);
    send_weight(-8'sd20, 32'h0000_0010, 1'b1);
    send_weight(8'sd5, 32'h0000_0010, 1'b0);
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd2);
    send_weight(8'sd40, 32'h0000_0010, 1'b0);
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd8);
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'h4000);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    repeat (3) send_random_row(8);
  endtask

  task automatic test_full_rows();
    write_reg(qmp_pkg::REG_ROW_LENGTH, 17'd127);
    write_reg(qmp_pkg::REG_CUT_FRACTION, qmp_pkg::RATIO_W'($urandom_range(65536)));
    send_random_row(ROW_MAX);
    write_reg(qmp_pkg::REG_ROW_LENGTH, qmp_pkg::CFG_DATA_W'(ROW_MAX));
    write_reg(qmp_pkg::REG_CUT_FRACTION, 17'hFFFF);
    send_random_row(ROW_MAX);
  endtask

  task automatic test_random_rows(input int unsigned src_pct, input int unsigned sink_pct,
                                  input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    logic [qmp_pkg::ROWLEN_W-1:0] len;
    logic [qmp_pkg::RATIO_W-1:0]  ratio;
    src_idle_pct = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 5) len = '0;
      else if (pick < 75) len = qmp_pkg::ROWLEN_W'($urandom_range(1, 8));
      else len = qmp_pkg::ROWLEN_W'($urandom_range(9, 16));
      case ($urandom_range(7))
        0:       ratio = '0;
        1:       ratio = qmp_pkg::RATIO_ONE;
        2:       ratio = qmp_pkg::RATIO_W'($urandom_range(65537, 131071));
        3:       ratio = 17'h8000;
        default: ratio = qmp_pkg::RATIO_W'($urandom_range(65536));
      endcase
      write_reg(qmp_pkg::REG_ROW_LENGTH, qmp_pkg::CFG_DATA_W'(len));
      write_reg(qmp_pkg::REG_CUT_FRACTION, ratio);
      repeat ($urandom_range(1, 3)) begin
        send_random_row(effective_length(len));
        sent += effective_length(len);
      end
    end
  endtask

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.weight      <= '0;
    in_bus.group_scale <= '0;
    in_bus.final_row   <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= qmp_pkg::REG_ROW_LENGTH;
    cfg_bus.data       <= '0;
    hold_go            <= 1'b0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    reg_writes         = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_threshold_ties();
    test_ratio_saturation();
    test_zero_row_length();
    test_length_lowered_midrow();
    test_output_backpressure();
    test_random_rows(0, 0, 20);
    test_random_rows(86, 0, 20);
    test_random_rows(0, 86, 20);
    test_random_rows(28, 28, 20);
    test_full_rows();

    wait_quiet(DRAIN_CYCLES);
    $display("covered %0d weights in, %0d rows and %0d pruned weights checked",
             weights_taken, rows_checked, results_checked);
    $display("%0d register writes: row lengths 0 to 127, ratios from zero to above one",
             reg_writes);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
